FILE: hdl/cgs_pkg.sv
// Shared types, codes and fixed-point helpers of the conjugate gradient solver.
// No dependencies; compiled first.
package cgs_pkg;

    // Function codes of an input request
    localparam logic [1:0] FUNC_MATRIX = 2'd0;
    localparam logic [1:0] FUNC_RHS    = 2'd1;
    localparam logic [1:0] FUNC_GUESS  = 2'd2;
    localparam logic [1:0] FUNC_START  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_SIZE  = 2'd0;
    localparam logic [1:0] CFG_TOL   = 2'd1;
    localparam logic [1:0] CFG_MAXIT = 2'd2;

    // Run status codes
    localparam logic [1:0] STATUS_CONV  = 2'd0;
    localparam logic [1:0] STATUS_LIMIT = 2'd1;
    localparam logic [1:0] STATUS_BREAK = 2'd2;

    // Results per run are capped by the 4-bit index field
    localparam int RES_LIMIT = 16;

    // Long division: 64 integer plus 16 fraction quotient bits
    localparam int DIV_STEPS = 80;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_WR_A,
        OP_WR_B,
        OP_WR_X,
        OP_AP,
        OP_INIT_R,
        OP_MUL,
        OP_SUM,
        OP_X_UPD,
        OP_RN_UPD,
        OP_P_UPD
    } cell_op_t;

    typedef enum logic [2:0] {
        MS_RR,
        MS_PAP,
        MS_RNRN,
        MS_SP,
        MS_SAP
    } mul_sel_t;

    typedef enum logic [1:0] {
        DOT_RR,
        DOT_PAP,
        DOT_RNN
    } dot_sel_t;

    typedef enum logic [1:0] {
        UPD_X,
        UPD_RN,
        UPD_P
    } upd_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MV,
        S_MV_AP,
        S_INIT_R,
        S_DOT_MUL,
        S_DOT_SUM,
        S_DOT_TAKE,
        S_DIV,
        S_UPD_MUL,
        S_UPD_WR,
        S_CHECK,
        S_OUT
    } ctrl_state_t;

    // Broadcast command from the sequencer to every cell
    typedef struct packed {
        cell_op_t    op;
        mul_sel_t    msel;
        logic [31:0] scalar;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [31:0] data;
    } cell_cmd_t;

    // Vector element travelling along the cell chain during A*v
    typedef struct packed {
        logic        valid;
        logic        first;
        logic [31:0] val;
    } vec_tok_t;

    typedef struct packed {
        logic [4:0]  size;
        logic [30:0] tol;
        logic [11:0] maxit;
    } cfg_t;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quot;
    } div_stat_t;

    function automatic logic signed [63:0] sx64(input logic signed [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    // Signed 64-bit add, clamped at the limits
    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    // Clamp a signed 64-bit value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if ((&v[63:31]) || !(|v[63:31]))
            return v[31:0];
        return v[63] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    endfunction

endpackage

FILE: hdl/cgs_in_if.sv
// Input request channel: valid/ready handshake and load/start payload.
// No dependencies.
interface cgs_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        func;
    logic [3:0]        row;
    logic [3:0]        col;
    logic signed [31:0] value;

    modport source (output valid, func, row, col, value, input ready);
    modport sink   (input valid, func, row, col, value, output ready);
endinterface

FILE: hdl/cgs_out_if.sv
// Result channel: valid/ready handshake and one solution element per request.
// No dependencies.
interface cgs_out_if;
    logic              valid;
    logic              ready;
    logic [3:0]        index;
    logic signed [31:0] solution_value;
    logic [12:0]       iterations;
    logic [1:0]        status;
    logic              last;

    modport source (output valid, index, solution_value, iterations, status, last,
                    input ready);
    modport sink   (input valid, index, solution_value, iterations, status, last,
                    output ready);
endinterface

FILE: hdl/cgs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

FILE: hdl/cgs_div.sv
// Restoring radix-2 divider giving a saturated signed Q16.16 quotient of two
// signed 64-bit values. Depends on cgs_pkg.
module cgs_div
    import cgs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  div_req_t  req,
    output div_stat_t stat
);
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [6:0]  step_reg, step_next;
    logic [79:0] dvd_reg, dvd_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] den_reg, den_next;
    logic [31:0] q_reg, q_next;
    logic        ovf_reg, ovf_next;
    logic        neg_reg, neg_next;
    logic        zero_reg, zero_next;

    logic [64:0] rem_sh;
    logic        ge;

    // One quotient bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        rem_sh    = {rem_reg, dvd_reg[79]};
        ge        = rem_sh >= {1'b0, den_reg};

        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = {(req.num[63] ? -req.num : req.num), 16'd0};
            den_next  = req.den[63] ? -req.den : req.den;
            rem_next  = '0;
            q_next    = '0;
            ovf_next  = 1'b0;
            neg_next  = req.num[63] ^ req.den[63];
            zero_next = (req.den == '0);
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? 64'(rem_sh - {1'b0, den_reg}) : rem_sh[63:0];
            q_next    = {q_reg[30:0], ge};
            ovf_next  = ovf_reg | q_reg[31];
            dvd_next  = {dvd_reg[78:0], 1'b0};
            step_next = step_reg + 7'd1;
            if (step_reg == 7'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        q_reg    <= q_next;
        ovf_reg  <= ovf_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    // Sign and saturation of the final quotient; a zero divisor gives zero
    always_comb
    begin
        stat.busy = busy_reg;
        stat.done = done_reg;
        if (zero_reg)
            stat.quot = '0;
        else if (ovf_reg || q_reg[31])
            stat.quot = neg_reg ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        else
            stat.quot = neg_reg ? -q_reg : q_reg;
    end
endmodule

FILE: hdl/cgs_cell.sv
// One cell of the solver chain: one row of A, one element of x, b, r, p, Ap.
// Depends on cgs_pkg and cgs_ram.
module cgs_cell
    import cgs_pkg::*;
#(
    parameter int MAX_SIZE = 16,
    parameter int CELL_ID  = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cell_cmd_t          cmd,
    input  vec_tok_t           prev_tok,
    output vec_tok_t           this_tok,
    input  logic signed [63:0] prev_sum,
    output logic signed [63:0] part_sum,
    output logic signed [31:0] x,
    output logic signed [31:0] p
);
    localparam int IDXW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

    vec_tok_t           tok_reg;
    logic [IDXW-1:0]    col_cnt_reg;
    logic [IDXW-1:0]    rd_addr;
    logic [31:0]        a_data;
    logic               row_hit;
    logic               col_ok;

    logic signed [31:0] x_reg, b_reg, r_reg, p_reg, ap_reg, rn_reg;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod_reg, acc_reg, sum_reg, prod_q;
    logic               mv_v_reg, mv_first_reg;

    assign row_hit = (32'(cmd.row) == CELL_ID);
    assign col_ok  = (32'(cmd.col) < MAX_SIZE);

    // Column counter follows the stream of vector elements
    assign rd_addr = prev_tok.first ? '0 : col_cnt_reg;

    cgs_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_row (
        .clk     (clk),
        .wr_en   (cmd.op == OP_WR_A && row_hit && col_ok),
        .wr_addr (IDXW'(cmd.col)),
        .wr_data (cmd.data),
        .rd_addr (rd_addr),
        .rd_data (a_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg     <= '0;
            col_cnt_reg <= '0;
            mv_v_reg    <= 1'b0;
        end
        else
        begin
            tok_reg  <= prev_tok;
            mv_v_reg <= tok_reg.valid;
            if (prev_tok.valid)
            begin
                col_cnt_reg <= rd_addr + 1'b1;
            end
        end
    end

    // Multiplier operands: matrix stream has priority over scalar products
    always_comb
    begin
        mul_a = a_data;
        mul_b = tok_reg.val;
        if (!tok_reg.valid)
        begin
            case (cmd.msel)
                MS_RR:   begin mul_a = r_reg;      mul_b = r_reg;  end
                MS_PAP:  begin mul_a = p_reg;      mul_b = ap_reg; end
                MS_RNRN: begin mul_a = rn_reg;     mul_b = rn_reg; end
                MS_SP:   begin mul_a = cmd.scalar; mul_b = p_reg;  end
                MS_SAP:  begin mul_a = cmd.scalar; mul_b = ap_reg; end
                default: begin mul_a = r_reg;      mul_b = r_reg;  end
            endcase
        end
    end

    assign prod_q = prod_reg >>> 16;

    // Product, row accumulator and dot-product chain
    always_ff @(posedge clk)
    begin
        if (tok_reg.valid || cmd.op == OP_MUL)
        begin
            prod_reg <= mul_a * mul_b;
        end
        mv_first_reg <= tok_reg.first;
        if (mv_v_reg)
        begin
            acc_reg <= sat_add64(mv_first_reg ? 64'sd0 : acc_reg, prod_reg);
        end
        if (cmd.op == OP_SUM)
        begin
            sum_reg <= sat_add64(prev_sum, prod_reg);
        end
    end

    // Element updates
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_WR_B:   if (row_hit) b_reg <= cmd.data;
            OP_WR_X:   if (row_hit) x_reg <= cmd.data;
            OP_AP:     ap_reg <= sat32(acc_reg >>> 16);
            OP_INIT_R:
            begin
                r_reg <= sat32(sx64(b_reg) - sx64(ap_reg));
                p_reg <= sat32(sx64(b_reg) - sx64(ap_reg));
            end
            OP_X_UPD:  x_reg  <= sat32(sx64(x_reg) + prod_q);
            OP_RN_UPD: rn_reg <= sat32(sx64(r_reg) - prod_q);
            OP_P_UPD:
            begin
                p_reg <= sat32(prod_q + sx64(rn_reg));
                r_reg <= rn_reg;
            end
            default: ;
        endcase
    end

    assign this_tok = tok_reg;
    assign part_sum = sum_reg;
    assign x        = x_reg;
    assign p        = p_reg;
endmodule

FILE: hdl/cgs_ctrl.sv
// Sequencer of the solver: loads, A*v streaming, dot products, divisions,
// vector updates, stop tests and result output. Depends on cgs_pkg and the
// channel interfaces.
module cgs_ctrl
    import cgs_pkg::*;
#(
    parameter int MAX_SIZE = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    cgs_in_if.sink             items,
    cgs_out_if.source          results,
    input  cfg_t               cfg,
    output cell_cmd_t          cmd,
    output vec_tok_t           feed,
    input  logic signed [31:0] x_vec [MAX_SIZE],
    input  logic signed [31:0] p_vec [MAX_SIZE],
    input  logic signed [63:0] sums  [MAX_SIZE],
    output div_req_t           div_req,
    input  div_stat_t          div_stat
);
    localparam int IDXW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int NLIM = (MAX_SIZE < RES_LIMIT) ? MAX_SIZE : RES_LIMIT;

    ctrl_state_t        state_reg, state_next;
    logic [6:0]         cnt_reg, cnt_next;
    logic [4:0]         n_reg, n_next;
    logic               mv_init_reg, mv_init_next;
    dot_sel_t           dot_sel_reg, dot_sel_next;
    upd_sel_t           upd_sel_reg, upd_sel_next;
    logic               beta_reg, beta_next;
    logic signed [63:0] rr_reg, rr_next;
    logic signed [63:0] pap_reg, pap_next;
    logic signed [63:0] rnn_reg, rnn_next;
    logic [31:0]        scalar_reg, scalar_next;
    logic [12:0]        count_reg, count_next;
    logic [1:0]         status_reg, status_next;
    logic [61:0]        tol2_reg;
    vec_tok_t           feed_reg, feed_next;

    logic               out_valid_reg, out_valid_next;
    logic [3:0]         out_index_reg, out_index_next;
    logic [31:0]        out_value_reg, out_value_next;
    logic [12:0]        out_iter_reg, out_iter_next;
    logic [1:0]         out_status_reg, out_status_next;
    logic               out_last_reg, out_last_next;

    logic               accept;
    logic [4:0]         n_eff;
    logic signed [31:0] vsel;
    logic signed [63:0] sum_last;

    assign items.ready = (state_reg == S_IDLE);
    assign accept      = items.valid && items.ready;

    // Effective system size: zero counts as one, else clamped to the available cells and result range
    always_comb
    begin
        if (cfg.size == 5'd0)
            n_eff = 5'd1;
        else if (32'(cfg.size) > NLIM)
            n_eff = 5'(NLIM);
        else
            n_eff = cfg.size;
    end

    // Vector element select shared by A*v feeding and result output
    assign vsel     = (mv_init_reg || state_reg == S_OUT) ? x_vec[IDXW'(cnt_reg)]
                                                          : p_vec[IDXW'(cnt_reg)];
    assign sum_last = sums[IDXW'(n_reg - 5'd1)];

    // Next state and cell commands
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        n_next          = n_reg;
        mv_init_next    = mv_init_reg;
        dot_sel_next    = dot_sel_reg;
        upd_sel_next    = upd_sel_reg;
        beta_next       = beta_reg;
        rr_next         = rr_reg;
        pap_next        = pap_reg;
        rnn_next        = rnn_reg;
        scalar_next     = scalar_reg;
        count_next      = count_reg;
        status_next     = status_reg;
        feed_next       = '0;
        out_valid_next  = out_valid_reg && !results.ready;
        out_index_next  = out_index_reg;
        out_value_next  = out_value_reg;
        out_iter_next   = out_iter_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        cmd.op     = OP_NOP;
        cmd.msel   = MS_RR;
        cmd.scalar = scalar_reg;
        cmd.row    = items.row;
        cmd.col    = items.col;
        cmd.data   = items.value;

        div_req.start = 1'b0;
        div_req.num   = rr_reg;
        div_req.den   = pap_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (items.func)
                        FUNC_MATRIX: cmd.op = OP_WR_A;
                        FUNC_RHS:    cmd.op = OP_WR_B;
                        FUNC_GUESS:  cmd.op = OP_WR_X;
                        FUNC_START:
                        begin
                            n_next       = n_eff;
                            mv_init_next = 1'b1;
                            cnt_next     = '0;
                            count_next   = '0;
                            state_next   = S_MV;
                        end
                        default: ;
                    endcase
                end
            end

            // Stream v into the chain, then wait for the last row to finish
            S_MV:
            begin
                if (cnt_reg < 7'(n_reg))
                begin
                    feed_next.valid = 1'b1;
                    feed_next.first = (cnt_reg == '0);
                    feed_next.val   = vsel;
                end
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'({n_reg, 1'b0}) + 7'd3)
                begin
                    state_next = S_MV_AP;
                end
            end

            S_MV_AP:
            begin
                cmd.op = OP_AP;
                if (mv_init_reg)
                begin
                    state_next = S_INIT_R;
                end
                else
                begin
                    dot_sel_next = DOT_RR;
                    state_next   = S_DOT_MUL;
                end
            end

            S_INIT_R:
            begin
                cmd.op       = OP_INIT_R;
                mv_init_next = 1'b0;
                count_next   = count_reg + 13'd1;
                cnt_next     = '0;
                state_next   = S_MV;
            end

            S_DOT_MUL:
            begin
                cmd.op = OP_MUL;
                case (dot_sel_reg)
                    DOT_RR:  cmd.msel = MS_RR;
                    DOT_PAP: cmd.msel = MS_PAP;
                    default: cmd.msel = MS_RNRN;
                endcase
                cnt_next   = '0;
                state_next = S_DOT_SUM;
            end

            // Partial sums ripple one cell per cycle
            S_DOT_SUM:
            begin
                cmd.op   = OP_SUM;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'(n_reg) - 7'd1)
                begin
                    state_next = S_DOT_TAKE;
                end
            end

            S_DOT_TAKE:
            begin
                case (dot_sel_reg)
                    DOT_RR:
                    begin
                        rr_next      = sum_last;
                        dot_sel_next = DOT_PAP;
                        state_next   = S_DOT_MUL;
                    end
                    DOT_PAP:
                    begin
                        pap_next = sum_last;
                        if (sum_last == '0)
                        begin
                            status_next = STATUS_BREAK;
                            cnt_next    = '0;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            div_req.start = 1'b1;
                            div_req.num   = rr_reg;
                            div_req.den   = sum_last;
                            beta_next     = 1'b0;
                            state_next    = S_DIV;
                        end
                    end
                    default:
                    begin
                        rnn_next      = sum_last;
                        div_req.start = 1'b1;
                        div_req.num   = sum_last;
                        div_req.den   = rr_reg;
                        beta_next     = 1'b1;
                        state_next    = S_DIV;
                    end
                endcase
            end

            S_DIV:
            begin
                if (div_stat.done)
                begin
                    scalar_next  = div_stat.quot;
                    upd_sel_next = beta_reg ? UPD_P : UPD_X;
                    state_next   = S_UPD_MUL;
                end
            end

            S_UPD_MUL:
            begin
                cmd.op     = OP_MUL;
                cmd.msel   = (upd_sel_reg == UPD_RN) ? MS_SAP : MS_SP;
                state_next = S_UPD_WR;
            end

            S_UPD_WR:
            begin
                case (upd_sel_reg)
                    UPD_X:
                    begin
                        cmd.op       = OP_X_UPD;
                        upd_sel_next = UPD_RN;
                        state_next   = S_UPD_MUL;
                    end
                    UPD_RN:
                    begin
                        cmd.op       = OP_RN_UPD;
                        dot_sel_next = DOT_RNN;
                        state_next   = S_DOT_MUL;
                    end
                    default:
                    begin
                        cmd.op     = OP_P_UPD;
                        state_next = S_CHECK;
                    end
                endcase
            end

            // Convergence is tested before the iteration limit
            S_CHECK:
            begin
                cnt_next = '0;
                if ($unsigned(rnn_reg) <= 64'(tol2_reg))
                begin
                    status_next = STATUS_CONV;
                    state_next  = S_OUT;
                end
                else if (count_reg > 13'(cfg.maxit))
                begin
                    status_next = STATUS_LIMIT;
                    state_next  = S_OUT;
                end
                else
                begin
                    count_next = count_reg + 13'd1;
                    state_next = S_MV;
                end
            end

            S_OUT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_index_next  = 4'(cnt_reg);
                    out_value_next  = vsel;
                    out_iter_next   = count_reg;
                    out_status_next = status_reg;
                    out_last_next   = (cnt_reg == 7'(n_reg) - 7'd1);
                    cnt_next        = cnt_reg + 7'd1;
                    if (cnt_reg == 7'(n_reg) - 7'd1)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            feed_reg      <= '0;
            out_valid_reg <= 1'b0;
            mv_init_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            feed_reg      <= feed_next;
            out_valid_reg <= out_valid_next;
            mv_init_reg   <= mv_init_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg        <= cnt_next;
        n_reg          <= n_next;
        dot_sel_reg    <= dot_sel_next;
        upd_sel_reg    <= upd_sel_next;
        beta_reg       <= beta_next;
        rr_reg         <= rr_next;
        pap_reg        <= pap_next;
        rnn_reg        <= rnn_next;
        scalar_reg     <= scalar_next;
        status_reg     <= status_next;
        tol2_reg       <= cfg.tol * cfg.tol;
        out_index_reg  <= out_index_next;
        out_value_reg  <= out_value_next;
        out_iter_reg   <= out_iter_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign feed                   = feed_reg;
    assign results.valid          = out_valid_reg;
    assign results.index          = out_index_reg;
    assign results.solution_value = out_value_reg;
    assign results.iterations     = out_iter_reg;
    assign results.status         = out_status_reg;
    assign results.last           = out_last_reg;

    // Divider is never restarted while a quotient is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_stat.busy)
        else $error("divider started while busy");

    // Every result reports at least one iteration
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_iter_reg != '0))
        else $error("result with zero iteration count");

    // Vector elements enter the chain only while streaming A*v
    assert property (@(posedge clk) disable iff (!rst_n)
        feed_reg.valid |-> $past(state_reg == S_MV))
        else $error("vector element fed outside A*v phase");
endmodule

FILE: hdl/conjugate_gradient_solver_unit.sv
// Top level of the conjugate gradient solver: configuration registers, the
// cell chain, the divider and the sequencer. Depends on cgs_pkg, cgs_in_if,
// cgs_out_if, cgs_cell, cgs_div and cgs_ctrl.
//
// Usage: requests on "items" load A (func 0), b (func 1) and the initial
// guess x (func 2), one per cycle while the block is idle. A start request
// (func 3) solves A x = b for the first n unknowns and then delivers n
// results on "results", row 0 first, with the iteration count and status;
// "last" marks row n-1. Solved x stays in place as the next warm start.
// Sequence: a solve starts with a set-up A*x pass that forms r and p, then
// per iteration A*v streams through the chain of n cells, each of three
// dot products ripples through the chain, two 80-step divisions run, and
// the vector updates and the stop test follow. Results then leave one per
// cycle while the receiver is ready. Input is held off from the start
// request until the last result is in the output register.
// Reset clears control state and loads the register defaults (n 16,
// tolerance 66, limit 160); stored vectors and A are undefined until
// loaded. A stalled receiver holds the output register and pauses output.
module conjugate_gradient_solver_unit
    import cgs_pkg::*;
#(
    parameter int MAX_SIZE = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    cgs_in_if.sink      items,
    cgs_out_if.source   results,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data
);
    cfg_t               cfg_reg;
    cell_cmd_t          cmd;
    vec_tok_t           feed;
    div_req_t           div_req;
    div_stat_t          div_stat;
    vec_tok_t           toks  [MAX_SIZE];
    logic signed [63:0] sums  [MAX_SIZE];
    logic signed [31:0] x_vec [MAX_SIZE];
    logic signed [31:0] p_vec [MAX_SIZE];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.size    <= 5'd16;
            cfg_reg.tol     <= 31'd66;
            cfg_reg.maxit   <= 12'd160;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SIZE:  cfg_reg.size  <= cfg_data[4:0];
                CFG_TOL:   cfg_reg.tol   <= cfg_data;
                CFG_MAXIT: cfg_reg.maxit <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // Chain of cells
    for (genvar i = 0; i < MAX_SIZE; i++)
    begin : g_cell
        cgs_cell #(.MAX_SIZE(MAX_SIZE), .CELL_ID(i)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .prev_tok ((i == 0) ? feed : toks[(i == 0) ? 0 : i - 1]),
            .this_tok (toks[i]),
            .prev_sum ((i == 0) ? 64'sd0 : sums[(i == 0) ? 0 : i - 1]),
            .part_sum (sums[i]),
            .x        (x_vec[i]),
            .p        (p_vec[i])
        );
    end

    cgs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    cgs_ctrl #(.MAX_SIZE(MAX_SIZE)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .items    (items),
        .results  (results),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .feed     (feed),
        .x_vec    (x_vec),
        .p_vec    (p_vec),
        .sums     (sums),
        .div_req  (div_req),
        .div_stat (div_stat)
    );
endmodule

FILE: verif/conjugate_gradient_solver_unit_tb.sv
// Testbench of the conjugate gradient solver: directed table, then random SPD systems,
// checked against an in-bench fixed-point solver. Depends on cgs_pkg, cgs_in_if, cgs_out_if.
module conjugate_gradient_solver_unit_tb;
    import cgs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0]  index;
        logic [31:0] value;
        logic [12:0] iters;
        logic [1:0]  status;
        logic        last;
    } solution_t;

    typedef struct {
        logic [1:0]  func;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [31:0] value;
        bit          typed;
        solution_t   sol;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [30:0] cfg_data;

    cgs_in_if  items();
    cgs_out_if results();

    conjugate_gradient_solver_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items.sink),
        .results   (results.source),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state
    int          mat_a [16][16];
    int          vec_b [16];
    int          vec_x [16];
    int          vec_r [16];
    int          vec_p [16];
    int          vec_ap [16];
    bit          wr_a [16][16];
    bit          wr_b [16];
    bit          wr_x [16];
    logic [4:0]  size_reg;
    logic [30:0] tol_reg;
    logic [11:0] maxit_reg;

    solution_t   pending_solutions[$];
    int          mismatches;
    int          sent_items;
    bit          calm;

    // Fixed settings: the size clamp first, then the extremes
    logic [4:0]  sizes [7] = '{5'd31, 5'd2, 5'd0, 5'd4, 5'd3, 5'd5, 5'd2};
    logic [30:0] tols  [7] = '{31'd655, 31'd0, 31'd1000, 31'h7fffffff, 31'd66, 31'd66,
                               31'd0};
    logic [11:0] lims  [7] = '{12'd8, 12'd0, 12'd10, 12'd4095, 12'd20, 12'd30, 12'd12};

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run time limit
    initial
    begin
        #500ms;
        $display("conjugate_gradient_solver_unit_tb: FAIL");
        $finish;
    end

    // ---------------- fixed-point arithmetic ----------------
    function automatic longint clamp_add64(input longint a, input longint b);
        longint s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            return a[63] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
        return s;
    endfunction

    function automatic int clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7fffffff;
        if (v < -64'sd2147483648)
            return 32'h80000000;
        return int'(v);
    endfunction

    function automatic longint qmul(input int a, input int b);
        return (longint'(a) * longint'(b)) >>> 16;
    endfunction

    function automatic longint dot_n(input int u [16], input int v [16], input int n);
        longint acc;
        acc = 0;
        for (int i = 0; i < n; i++)
            acc = clamp_add64(acc, longint'(u[i]) * longint'(v[i]));
        return acc;
    endfunction

    // Q16.16 quotient of two Q32.32 sums, truncated, magnitude clamped
    function automatic int q_divide(input longint num, input longint den);
        bit                neg;
        bit                top;
        longint unsigned   un;
        longint unsigned   ud;
        longint unsigned   q;
        longint unsigned   rem;
        longint unsigned   mag;
        if (den == 0)
            return 0;
        neg = (num < 0) != (den < 0);
        un = num;
        ud = den;
        if (num < 0)
            un = ~un + 1;
        if (den < 0)
            ud = ~ud + 1;
        q = un / ud;
        if (q >= 32768)
            return neg ? 32'h80000000 : 32'h7fffffff;
        rem = un % ud;
        mag = q;
        for (int k = 0; k < 16; k++)
        begin
            top = rem[63];
            rem = rem << 1;
            mag = mag << 1;
            if (top || rem >= ud)
            begin
                rem = rem - ud;
                mag = mag | 1;
            end
        end
        return neg ? int'(0 - mag) : int'(mag);
    endfunction

    function automatic int unknowns();
        if (size_reg < 1)
            return 1;
        if (size_reg > 16)
            return 16;
        return size_reg;
    endfunction

    task automatic mat_times(input int v [16], input int n);
        longint acc;
        for (int i = 0; i < n; i++)
        begin
            acc = 0;
            for (int j = 0; j < n; j++)
                acc = clamp_add64(acc, longint'(mat_a[i][j]) * longint'(v[j]));
            vec_ap[i] = clamp32(acc >>> 16);
        end
    endtask

    // Runs one solve and queues one solution element per row
    task automatic cg_solve();
        int                n;
        int                count;
        int                alpha;
        int                beta;
        int                rn [16];
        logic [1:0]        status;
        longint            rr;
        longint            pap;
        longint            rnn;
        longint unsigned   tol2;
        solution_t         s;
        n = unknowns();
        count = 0;
        tol2 = longint'(tol_reg) * longint'(tol_reg);
        mat_times(vec_x, n);
        for (int i = 0; i < n; i++)
        begin
            vec_r[i] = clamp32(longint'(vec_b[i]) - longint'(vec_ap[i]));
            vec_p[i] = vec_r[i];
        end
        forever
        begin
            count++;
            mat_times(vec_p, n);
            rr = dot_n(vec_r, vec_r, n);
            pap = dot_n(vec_p, vec_ap, n);
            if (pap == 0)
            begin
                status = STATUS_BREAK;
                break;
            end
            alpha = q_divide(rr, pap);
            for (int i = 0; i < n; i++)
            begin
                vec_x[i] = clamp32(longint'(vec_x[i]) + qmul(alpha, vec_p[i]));
                rn[i] = clamp32(longint'(vec_r[i]) - qmul(alpha, vec_ap[i]));
            end
            rnn = dot_n(rn, rn, n);
            beta = q_divide(rnn, rr);
            for (int i = 0; i < n; i++)
            begin
                vec_p[i] = clamp32(qmul(beta, vec_p[i]) + longint'(rn[i]));
                vec_r[i] = rn[i];
            end
            if ($unsigned(rnn) <= tol2)
            begin
                status = STATUS_CONV;
                break;
            end
            if (count > maxit_reg)
            begin
                status = STATUS_LIMIT;
                break;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            s.index = 4'(i);
            s.value = vec_x[i];
            s.iters = 13'(count);
            s.status = status;
            s.last = (i == n - 1);
            pending_solutions.push_back(s);
            wr_x[i] = 1'b1;
        end
    endtask

    // Applies one accepted request to the predictor
    task automatic predict(input logic [1:0] f, input logic [3:0] r, input logic [3:0] c,
                           input logic [31:0] v);
        case (f)
            FUNC_MATRIX:
            begin
                mat_a[r][c] = v;
                wr_a[r][c] = 1'b1;
            end
            FUNC_RHS:
            begin
                vec_b[r] = v;
                wr_b[r] = 1'b1;
            end
            FUNC_GUESS:
            begin
                vec_x[r] = v;
                wr_x[r] = 1'b1;
            end
            default:
                cg_solve();
        endcase
    endtask

    function automatic bit all_loaded();
        int n;
        n = unknowns();
        for (int i = 0; i < n; i++)
        begin
            if (!wr_b[i] || !wr_x[i])
                return 1'b0;
            for (int j = 0; j < n; j++)
                if (!wr_a[i][j])
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // ---------------- request side ----------------
    task automatic send(input logic [1:0] f, input logic [3:0] r, input logic [3:0] c,
                        input logic [31:0] v);
        while (!calm && $urandom_range(99) < 20)
        begin
            items.valid <= 1'b0;
            @(posedge clk);
        end
        items.valid <= 1'b1;
        items.func  <= f;
        items.row   <= r;
        items.col   <= c;
        items.value <= v;
        do
            @(posedge clk);
        while (!items.ready);
        predict(f, r, c, v);
        sent_items++;
    endtask

    // Waits for every pending solution, then lets the block settle
    task automatic drain();
        items.valid <= 1'b0;
        while (pending_solutions.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [30:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_SIZE: size_reg = data[4:0];
            CFG_TOL:  tol_reg = data;
            default:  maxit_reg = data[11:0];
        endcase
    endtask

    task automatic configure(input logic [4:0] sz, input logic [30:0] tol,
                             input logic [11:0] maxit);
        drain();
        set_reg(CFG_SIZE, sz);
        set_reg(CFG_TOL, tol);
        set_reg(CFG_MAXIT, maxit);
        cfg_write <= 1'b0;
    endtask

    // Loads a diagonally dominant symmetric system and, unless broken, starts a solve
    task automatic run_system(input bit broken);
        int n;
        int off;
        n = unknowns();
        for (int i = 0; i < n; i++)
            for (int j = i; j < n; j++)
            begin
                if (i == j)
                    mat_a[i][i] = 0;
                off = (i == j) ? (n + 1) * 65536 + $urandom_range(3 * 65536)
                               : $signed($urandom_range(131072)) - 65536;
                send(FUNC_MATRIX, 4'(i), 4'(j), off);
                if (i != j)
                    send(FUNC_MATRIX, 4'(j), 4'(i), off);
            end
        for (int i = 0; i < n; i++)
            send(FUNC_RHS, 4'(i), 4'($urandom), $signed($urandom_range(1048576)) - 524288);
        if ($urandom_range(1) || !all_loaded())
            for (int i = 0; i < n; i++)
                send(FUNC_GUESS, 4'(i), 4'($urandom),
                     $signed($urandom_range(524288)) - 262144);
        if (!broken)
            send(FUNC_START, 4'($urandom), 4'($urandom), $urandom);
    endtask

    // Random loads, with an occasional start when every needed entry exists
    task automatic noise(input int count);
        logic [1:0] f;
        for (int k = 0; k < count; k++)
        begin
            f = 2'($urandom_range(3));
            if (f == FUNC_START && !all_loaded())
                f = FUNC_MATRIX;
            send(f, 4'($urandom), 4'($urandom), $urandom);
        end
    endtask

    // ---------------- result side ----------------
    always @(posedge clk)
    begin
        solution_t got;
        solution_t want;
        if (!rst_n)
            results.ready <= 1'b0;
        else
        begin
            if (results.valid && results.ready)
            begin
                got = '{results.index, results.solution_value, results.iterations,
                        results.status, results.last};
                if (pending_solutions.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected solution element: %p", got);
                end
                else
                begin
                    want = pending_solutions.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("solution mismatch: expected %p, got %p", want, got);
                    end
                end
            end
            results.ready <= calm || ($urandom_range(99) >= 20);
        end
    end

    // ---------------- directed table ----------------
    stim_row_t table_rows [$] = '{
        '{FUNC_MATRIX, 0, 0, 32'h00010000, 0, '0},
        '{FUNC_RHS,    0, 0, 32'h00020000, 0, '0},
        '{FUNC_GUESS,  0, 0, 32'h00000000, 0, '0},
        // one step lands exactly on x = 2.0
        '{FUNC_START,  0, 0, 32'h0, 1, '{4'd0, 32'h00020000, 13'd1, STATUS_CONV, 1'b1}},
        // warm start on the exact answer: zero residual breaks down
        '{FUNC_START,  15, 15, 32'hffffffff, 1,
          '{4'd0, 32'h00020000, 13'd1, STATUS_BREAK, 1'b1}},
        '{FUNC_MATRIX, 15, 15, 32'h7fffffff, 0, '0},
        '{FUNC_RHS,    15, 0, 32'h80000000, 0, '0},
        '{FUNC_GUESS,  15, 0, 32'h7fffffff, 0, '0},
        '{FUNC_MATRIX, 0, 15, 32'h80000000, 0, '0},
        '{FUNC_MATRIX, 0, 0, 32'h7fffffff, 0, '0},
        '{FUNC_RHS,    0, 0, 32'h80000000, 0, '0},
        '{FUNC_GUESS,  0, 0, 32'h00000000, 0, '0},
        '{FUNC_START,  0, 0, 32'h0, 0, '0},
        '{FUNC_MATRIX, 0, 0, 32'h00000000, 0, '0},
        '{FUNC_START,  0, 0, 32'h0, 0, '0},
        '{FUNC_GUESS,  0, 0, 32'h00010000, 0, '0},
        '{FUNC_MATRIX, 0, 0, 32'h80000000, 0, '0},
        '{FUNC_RHS,    0, 0, 32'h7fffffff, 0, '0},
        '{FUNC_START,  0, 0, 32'h0, 0, '0}
    };

    initial
    begin
        int phase;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_SIZE;
        cfg_data = '0;
        items.valid = 1'b0;
        items.func = FUNC_MATRIX;
        items.row = '0;
        items.col = '0;
        items.value = '0;
        results.ready = 1'b0;
        mismatches = 0;
        sent_items = 0;
        calm = 1'b0;
        size_reg = 5'd16;
        tol_reg = 31'd66;
        maxit_reg = 12'd160;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_reg(CFG_SIZE, 5'd1);
        cfg_write <= 1'b0;
        foreach (table_rows[k])
        begin
            send(table_rows[k].func, table_rows[k].row, table_rows[k].col,
                 table_rows[k].value);
            if (table_rows[k].typed)
                pending_solutions[pending_solutions.size() - 1] = table_rows[k].sol;
        end

        // Fixed settings including the extremes, then random ones
        phase = 0;
        while (phase < 4 || sent_items < 360)
        begin
            if (phase < 7)
                configure(sizes[phase], tols[phase], lims[phase]);
            else
                configure(5'($urandom_range(1, 6)), 31'($urandom_range(2000)),
                          12'($urandom_range(1, 25)));
            calm = (phase == 3);
            run_system(1'b0);
            if ($urandom_range(3) == 0 && unknowns() < 16)
                run_system(1'b1);
            if (unknowns() < 16)
                run_system(1'b0);
            noise($urandom_range(2, 6));
            phase++;
        end
        calm = 1'b0;

        drain();
        repeat (50) @(posedge clk);
        if (mismatches == 0 && pending_solutions.size() == 0)
            $display("conjugate_gradient_solver_unit_tb: PASS");
        else
            $display("conjugate_gradient_solver_unit_tb: FAIL");
        $finish;
    end

endmodule
